>>> rtl/mpp_pkg.sv
// Shared types, sizes and helper functions of the Markov page prefetch block.
// No dependencies; every other file of the block but mpp_ram imports this package.
package mpp_pkg;

    localparam int NUM_PROCS      = 16;
    localparam int PAGES_PER_PROC = 16;
    localparam int PAGE_BYTES     = 128;

    localparam int PID_W    = 4;
    localparam int PC_W     = 11;
    localparam int MAP_BITS = 16;
    localparam int OUT_PG_W = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PROC_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PAGE_W     = $clog2(PAGES_PER_PROC);
    localparam int NP_DEPTH   = NUM_PROCS * PAGES_PER_PROC;
    localparam int NP_AW      = $clog2(NP_DEPTH);

    typedef logic [PROC_W-1:0]   proc_idx_t;
    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [NP_AW-1:0]    np_addr_t;
    typedef logic [MAP_BITS-1:0] map_t;

    // Read addresses issued when a request is accepted
    typedef struct packed {
        proc_idx_t lp_addr;
        np_addr_t  np_addr;
    } rd_req_t;

    // Table updates from the decision stage
    typedef struct packed {
        logic      lp_we;
        proc_idx_t lp_addr;
        logic      np_we;
        np_addr_t  np_addr;
        page_t     page;
    } upd_t;

    // Table contents seen by the decision stage, forwarding applied
    typedef struct packed {
        logic  lp_valid;
        page_t lp_page;
        logic  np_valid;
        page_t np_page;
    } look_t;

    // Request held in the decision stage
    typedef struct packed {
        logic                handled;
        logic [PID_W-1:0]    pid;
        proc_idx_t           pid_idx;
        page_t               page;
        map_t                res;
    } item_t;

    typedef struct packed {
        logic [PID_W-1:0]    proc_id;
        map_t                evict_mask;
        logic                load_now;
        logic [OUT_PG_W-1:0] load_now_page;
        logic                prefetch;
        logic [OUT_PG_W-1:0] prefetch_page;
    } result_t;

    function automatic np_addr_t np_index(input proc_idx_t pid, input page_t page);
        return NP_AW'(pid) * NP_AW'(PAGES_PER_PROC) + NP_AW'(page);
    endfunction

    // One-hot bit of a page in the resident map; pages past the map are never resident
    function automatic map_t page_bit(input page_t page);
        map_t b;
        b = '0;
        if (int'(page) < MAP_BITS) begin
            b = map_t'(1) << page;
        end
        return b;
    endfunction

    function automatic logic [OUT_PG_W-1:0] page_out(input page_t page);
        logic [PAGE_W+OUT_PG_W-1:0] w;
        w = (PAGE_W + OUT_PG_W)'(page);
        return w[OUT_PG_W-1:0];
    endfunction

endpackage

>>> rtl/markov_page_prefetch_policy_top.sv
// Top level of the Markov next-page prefetch policy block.
// Depends on mpp_pkg, mpp_state (with mpp_ram) and mpp_decide.
//
// Usage:
//   Each request on the s_ stream is one process status for one tick:
//   s_tdata[3:0] proc_id, [4] active, [15:5] prog_counter, [31:16] resident map.
//   Each request produces exactly one record on the m_ stream carrying the
//   evict mask, the load-now page and the prefetch page for that process.
//   The consumer orders the actual page-out and page-in calls.
//
//   A request accepted on s_ loads the decision stage, and the table reads
//   issue together with that load; the output register loads when the decision
//   stage advances, and the record is then presented on m_.
//   Throughput: one request per cycle while m_ does not stall. The per-process
//   read-modify-write of the last-page and next-page RAMs is closed by forwarding
//   the write issued on the same edge as a read, so back-to-back requests of one
//   process need no bubble.
//
//   Reset (aresetn low, synchronous) empties the pipeline and clears all
//   history valid bits at once; RAM contents are left as they are and are
//   never used before being written. No clearing pass follows reset.
//
//   When m_tready is low the output register holds its record, the decision
//   stage holds its request, and s_tready drops only once both are full.
module markov_page_prefetch_policy_top
    import mpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [3:0] proc_id, [4] active, [15:5] prog_counter, [31:16] resident_pages
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [3:0] out_proc_id, [19:4] evict_mask, [20] load_now, [24:21] load_now_page,
    // [25] prefetch, [29:26] prefetch_page, [31:30] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                s_fire;
    logic                s1_adv;
    logic                s1_valid_reg;
    item_t               s1_reg;
    item_t               s1_next;
    logic                m_valid_reg;
    result_t             m_reg;
    result_t             dec_res;

    logic [PID_W-1:0]    in_pid;
    logic                in_active;
    logic [PC_W-1:0]     in_pc;
    logic [PC_W-1:0]     page_raw;
    rd_req_t             rd;
    upd_t                upd;
    look_t               look;

    // Unpack the request
    assign in_pid    = s_tdata[PID_W-1:0];
    assign in_active = s_tdata[PID_W];
    assign in_pc     = s_tdata[PID_W+PC_W:PID_W+1];

    // Page = counter / page size, saturated to the last page of the process
    assign page_raw = in_pc >> PAGE_SHIFT;

    always_comb begin
        s1_next.handled = in_active && (int'(in_pid) < NUM_PROCS);
        s1_next.pid     = in_pid;
        s1_next.pid_idx = PROC_W'(in_pid);
        s1_next.res     = s_tdata[PID_W+PC_W+MAP_BITS:PID_W+PC_W+1];
        if (int'(page_raw) >= PAGES_PER_PROC) begin
            s1_next.page = PAGE_W'(PAGES_PER_PROC - 1);
        end else begin
            s1_next.page = PAGE_W'(page_raw);
        end
        rd.lp_addr = s1_next.pid_idx;
        rd.np_addr = np_index(s1_next.pid_idx, s1_next.page);
    end

    // Advance the decision stage whenever the output register frees up
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    mpp_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd      (rd),
        .upd     (upd),
        .look    (look)
    );

    mpp_decide u_decide (
        .item    (s1_reg),
        .look    (look),
        .advance (s1_adv),
        .upd     (upd),
        .res     (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on a move, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg <= s1_next;
        end
        if (s1_adv) begin
            m_reg <= dec_res;
        end
    end

    // Pack the record with the process id in the lowest bits
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_reg.prefetch_page, m_reg.prefetch, m_reg.load_now_page,
                       m_reg.load_now, m_reg.evict_mask, m_reg.proc_id};

    // Reset empties both stages
    assert property (@(posedge aclk) !aresetn |=> !s1_valid_reg && !m_valid_reg)
        else $error("pipeline not empty after reset");

    // A successor is recorded only together with a last-page update
    assert property (@(posedge aclk) disable iff (!aresetn) upd.np_we |-> upd.lp_we)
        else $error("next-page write without last-page write");

    // Tables change only when a request leaves the decision stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (upd.lp_we || upd.np_we) |-> s1_valid_reg && s1_adv)
        else $error("table write without advancing request");

    // A new record appears only after the decision stage moved
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_adv))
        else $error("output valid without a source request");

    // Empty decision stage always accepts
    assert property (@(posedge aclk) disable iff (!aresetn) !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty decision stage");

endmodule

>>> rtl/mpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mpp_state.sv
// Per-process history tables: last page and next-page RAMs, their valid flops
// and write-to-read forwarding. Depends on mpp_pkg and mpp_ram.
module mpp_state
    import mpp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    rd_en,
    input  rd_req_t rd,
    input  upd_t    upd,
    output look_t   look
);

    logic [NUM_PROCS-1:0] lp_valid_reg;
    logic [NP_DEPTH-1:0]  np_valid_reg;
    proc_idx_t            lp_addr_reg;
    np_addr_t             np_addr_reg;
    page_t                lp_rdata;
    page_t                np_rdata;

    // Write landing on the same edge as the read: the RAM returns old data
    logic                 byp_lp_reg;
    proc_idx_t            byp_lp_addr_reg;
    logic                 byp_np_reg;
    np_addr_t             byp_np_addr_reg;
    page_t                byp_page_reg;
    page_t                byp_np_page_reg;

    mpp_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PROCS), .AW(PROC_W)) u_last_ram (
        .aclk  (aclk),
        .we    (upd.lp_we),
        .waddr (upd.lp_addr),
        .wdata (upd.page),
        .re    (rd_en),
        .raddr (rd.lp_addr),
        .rdata (lp_rdata)
    );

    mpp_ram #(.WIDTH(PAGE_W), .DEPTH(NP_DEPTH), .AW(NP_AW)) u_next_ram (
        .aclk  (aclk),
        .we    (upd.np_we),
        .waddr (upd.np_addr),
        .wdata (upd.page),
        .re    (rd_en),
        .raddr (rd.np_addr),
        .rdata (np_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_valid_reg <= '0;
            np_valid_reg <= '0;
            byp_lp_reg   <= 1'b0;
            byp_np_reg   <= 1'b0;
        end else begin
            if (upd.lp_we) begin
                lp_valid_reg[upd.lp_addr] <= 1'b1;
            end
            if (upd.np_we) begin
                np_valid_reg[upd.np_addr] <= 1'b1;
            end
            if (rd_en) begin
                byp_lp_reg <= upd.lp_we;
                byp_np_reg <= upd.np_we;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lp_addr_reg     <= rd.lp_addr;
            np_addr_reg     <= rd.np_addr;
            byp_lp_addr_reg <= upd.lp_addr;
            byp_np_addr_reg <= upd.np_addr;
            byp_page_reg    <= upd.page;
            byp_np_page_reg <= upd.page;
        end
    end

    always_comb begin
        look.lp_valid = lp_valid_reg[lp_addr_reg];
        look.np_valid = np_valid_reg[np_addr_reg];
        look.lp_page  = (byp_lp_reg && byp_lp_addr_reg == lp_addr_reg) ? byp_page_reg
                                                                          : lp_rdata;
        look.np_page  = (byp_np_reg && byp_np_addr_reg == np_addr_reg) ? byp_np_page_reg
                                                                          : np_rdata;
    end

endmodule

>>> rtl/mpp_decide.sv
// Decision logic: history update and load, prefetch and evict commands for the
// request in the decision stage. Depends on mpp_pkg.
module mpp_decide
    import mpp_pkg::*;
(
    input  item_t   item,
    input  look_t   look,
    input  logic    advance,
    output upd_t    upd,
    output result_t res
);

    logic page_moved;
    map_t keep;
    map_t pf_bit;

    always_comb begin
        page_moved = look.lp_valid && (look.lp_page != item.page);

        // Learn: first tick loads last page, a page change also records the successor
        upd.lp_we   = advance && item.handled && (!look.lp_valid || page_moved);
        upd.lp_addr = item.pid_idx;
        upd.np_we   = advance && item.handled && page_moved;
        upd.np_addr = np_index(item.pid_idx, look.lp_page);
        upd.page    = item.page;

        pf_bit = page_bit(look.np_page);
        keep   = page_bit(item.page);
        if (look.np_valid) begin
            keep = keep | pf_bit;
        end

        res.proc_id       = item.pid;
        res.evict_mask    = item.res;
        res.load_now      = 1'b0;
        res.load_now_page = '0;
        res.prefetch      = 1'b0;
        res.prefetch_page = '0;
        if (item.handled) begin
            res.evict_mask    = item.res & ~keep;
            res.load_now      = ~|(item.res & page_bit(item.page));
            res.load_now_page = page_out(item.page);
            if (look.np_valid) begin
                res.prefetch      = ~|(item.res & pf_bit);
                res.prefetch_page = page_out(look.np_page);
            end
        end
    end

endmodule

>>> tb/mpp_policy_checker.sv
`timescale 1ns / 1ps
// Checker for the Markov page prefetch block: predicts one record per accepted
// request and compares it with the m_ stream. Depends on mpp_pkg.
module mpp_policy_checker
    import mpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);

    // Own copy of the per-process history
    int cur_page   [NUM_PROCS];
    bit cur_valid  [NUM_PROCS];
    int succ_page  [NUM_PROCS*PAGES_PER_PROC];
    bit succ_valid [NUM_PROCS*PAGES_PER_PROC];

    result_t expected_records[$];

    function automatic map_t page_onehot(input int pg);
        map_t b;
        b = '0;
        if (pg < MAP_BITS) begin
            b[pg] = 1'b1;
        end
        return b;
    endfunction

    function automatic result_t predict_record(input logic [S_DATA_W-1:0] word);
        result_t     r;
        logic [3:0]  pid;
        logic        act;
        logic [10:0] pc;
        map_t        res;
        map_t        keep;
        int          pg;
        int          prev;
        int          base;
        int          nxt;
        pid = word[3:0];
        act = word[4];
        pc  = word[15:5];
        res = word[31:16];
        r.proc_id       = pid;
        r.evict_mask    = res;
        r.load_now      = 1'b0;
        r.load_now_page = '0;
        r.prefetch      = 1'b0;
        r.prefetch_page = '0;
        if (act && int'(pid) < NUM_PROCS) begin
            pg = int'(pc) / PAGE_BYTES;
            if (pg >= PAGES_PER_PROC) begin
                pg = PAGES_PER_PROC - 1;
            end
            base = int'(pid) * PAGES_PER_PROC;
            if (!cur_valid[pid]) begin
                cur_page[pid]  = pg;
                cur_valid[pid] = 1'b1;
            end else if (cur_page[pid] != pg) begin
                prev = cur_page[pid];
                if (prev < PAGES_PER_PROC) begin
                    succ_page[base+prev]  = pg;
                    succ_valid[base+prev] = 1'b1;
                end
                cur_page[pid] = pg;
            end
            keep            = page_onehot(pg);
            r.load_now      = ((res & keep) == '0);
            r.load_now_page = 4'(pg);
            if (succ_valid[base+pg]) begin
                nxt             = succ_page[base+pg];
                keep           |= page_onehot(nxt);
                r.prefetch_page = 4'(nxt);
                r.prefetch      = ((res & page_onehot(nxt)) == '0);
            end
            r.evict_mask = res & ~keep;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                cur_valid[i] = 1'b0;
            end
            for (int i = 0; i < NUM_PROCS*PAGES_PER_PROC; i++) begin
                succ_valid[i] = 1'b0;
            end
            expected_records.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.proc_id       = m_tdata[3:0];
                got.evict_mask    = m_tdata[19:4];
                got.load_now      = m_tdata[20];
                got.load_now_page = m_tdata[24:21];
                got.prefetch      = m_tdata[25];
                got.prefetch_page = m_tdata[29:26];
                if (expected_records.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected record: pid %0d evict %h ld %b/%0d pf %b/%0d",
                                 got.proc_id, got.evict_mask, got.load_now,
                                 got.load_now_page, got.prefetch, got.prefetch_page);
                    end
                end else begin
                    want = expected_records.pop_front();
                    if (want.proc_id !== got.proc_id || want.evict_mask !== got.evict_mask ||
                        want.load_now !== got.load_now ||
                        want.load_now_page !== got.load_now_page ||
                        want.prefetch !== got.prefetch ||
                        want.prefetch_page !== got.prefetch_page) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: exp pid %0d evict %h ld %b/%0d pf %b/%0d",
                                     want.proc_id, want.evict_mask, want.load_now,
                                     want.load_now_page, want.prefetch, want.prefetch_page);
                            $display("          got pid %0d evict %h ld %b/%0d pf %b/%0d",
                                     got.proc_id, got.evict_mask, got.load_now,
                                     got.load_now_page, got.prefetch, got.prefetch_page);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_records.push_back(predict_record(s_tdata));
            end
        end
        pending = expected_records.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, request stimulus and result back-pressure
// for markov_page_prefetch_policy_top. Depends on mpp_pkg and mpp_policy_checker.
module testbench;
    import mpp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 600;
    localparam int MAX_ROUTE    = 6;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count;

    // Idle odds in percent, set by blocking assignment at start, nonblocking later
    int src_idle_pct;
    int sink_idle_pct;
    logic hold_arm;

    // Page routes that the well-formed random requests walk per process
    int route_page [NUM_PROCS][MAX_ROUTE];
    int route_len  [NUM_PROCS];
    int route_pos  [NUM_PROCS];
    int hot_pid    [4];

    markov_page_prefetch_policy_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mpp_policy_checker policy_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // Abort the run if it hangs
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Drive m_tready at the falling edge: random idling, plus one long hold-off
    // once armed, so the pipeline fills and s_tready drops while requests wait.
    initial begin : sink_drive
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_arm && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Pack one status request: proc_id, active, prog_counter, resident map
    function automatic logic [S_DATA_W-1:0] status_word(input int pid, input bit act,
                                                        input int pc, input int res);
        return {16'(res), 11'(pc), act, 4'(pid)};
    endfunction

    // Offer one request; enter and leave at a falling edge. Idle gaps lower
    // tvalid; a back-to-back request keeps it high without a dip.
    task automatic push_status(input logic [S_DATA_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender off until every expected record has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic reroute(input int p);
        route_len[p] = $urandom_range(MAX_ROUTE, 2);
        route_pos[p] = 0;
        for (int k = 0; k < MAX_ROUTE; k++) begin
            route_page[p][k] = $urandom_range(PAGES_PER_PROC - 1);
        end
    endtask

    task automatic pick_hot_pids();
        for (int k = 0; k < 4; k++) begin
            hot_pid[k] = $urandom_range(NUM_PROCS - 1);
        end
    endtask

    // Mostly well-formed walks along each process's route with random offsets
    // and residency; the rest is inactive requests and random page jumps.
    task automatic run_random(input int count);
        int          roll;
        int          pid;
        int          pg;
        int          pc;
        logic [15:0] res;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            pid  = ($urandom_range(99) < 80) ? hot_pid[$urandom_range(3)]
                                             : $urandom_range(NUM_PROCS - 1);
            case ($urandom_range(3))
                0: res = 16'($urandom);
                1: res = 16'($urandom & $urandom);
                2: res = 16'h0000;
                default: res = 16'($urandom | $urandom);
            endcase
            if (roll < 80) begin
                pg = route_page[pid][route_pos[pid]];
                pc = pg * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
                if ($urandom_range(1) == 1) begin
                    res[pg] = ~res[pg];
                end
                push_status(status_word(pid, 1'b1, pc, res));
                if ($urandom_range(2) != 0) begin
                    route_pos[pid] = (route_pos[pid] + 1) % route_len[pid];
                end
            end else if (roll < 90) begin
                push_status(status_word(pid, 1'b0, $urandom_range(2047), res));
            end else begin
                push_status(status_word(pid, 1'b1, $urandom_range(2047), res));
                if ($urandom_range(3) == 0) begin
                    reroute(pid);
                end
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        src_idle_pct  = 16;
        sink_idle_pct = 57;
        hold_arm      = 1'b0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            reroute(p);
        end
        pick_hot_pids();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: inactive extremes evict everything resident
        push_status(status_word(0, 1'b0, 0, 16'hFFFF));
        push_status(status_word(15, 1'b0, 2047, 16'h0000));
        // First active tick, then the same page again, resident
        push_status(status_word(0, 1'b1, 0, 16'h0000));
        push_status(status_word(0, 1'b1, 127, 16'h0001));
        // Jump to the top page with every page resident
        push_status(status_word(0, 1'b1, 2047, 16'hFFFF));
        // Back to page 0: now page 15 is the known successor of page 0
        push_status(status_word(0, 1'b1, 0, 16'h0000));
        push_status(status_word(0, 1'b1, 128, 16'h8003));
        // Page 0 again predicts page 1, which is not resident here
        push_status(status_word(0, 1'b1, 5, 16'h8001));
        // Inactive tick of a tracked process leaves its history alone
        push_status(status_word(0, 1'b0, 1500, 16'hFFFF));
        push_status(status_word(0, 1'b1, 300, 16'hFFFF));
        push_status(status_word(0, 1'b1, 64, 16'hFFFF));
        // Second process, first tick in the middle of its pages
        push_status(status_word(15, 1'b1, 1024, 16'h0100));
        push_status(status_word(15, 1'b1, 1100, 16'h0100));
        push_status(status_word(15, 1'b1, 1152, 16'h0000));
        // Back to page 8: prediction of page 9 resident, then not
        push_status(status_word(15, 1'b1, 1030, 16'h0300));
        push_status(status_word(15, 1'b1, 1030, 16'h0000));
        push_status(status_word(7, 1'b1, 3 * 128, 16'hAAAA));
        push_status(status_word(7, 1'b1, 3 * 128 + 127, 16'h5555));
        push_status(status_word(7, 1'b1, 4 * 128, 16'hFFFF));
        push_status(status_word(7, 1'b1, 3 * 128 + 9, 16'h0008));

        // Pause the sender until the directed records are all back
        wait_drained();

        // Phase 1: sender idles lightly, receiver heavily
        run_random(PHASE_ITEMS);

        // Phase 2: swap the idling
        src_idle_pct  <= 57;
        sink_idle_pct <= 16;
        pick_hot_pids();
        run_random(PHASE_ITEMS);
        wait_drained();

        // Phase 3: no idling, with one long receiver hold-off early on
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        hold_arm      <= 1'b1;
        pick_hot_pids();
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mpp_pkg.sv
rtl/mpp_ram.sv
rtl/mpp_state.sv
rtl/mpp_decide.sv
rtl/markov_page_prefetch_policy_top.sv
tb/mpp_policy_checker.sv
tb/testbench.sv
